// ===== sv/sorted_key_value_table_defines.svh =====
// Assertion macros shared by the sorted key-value table modules.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef SORTED_KEY_VALUE_TABLE_DEFINES_SVH
`define SORTED_KEY_VALUE_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SKVT_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SKVT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/skvt_pkg.sv =====
// Shared types and constants of the sorted key-value table.
// No dependencies; the controller, datapath, top level and testbench import this package.
package skvt_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 256;
  localparam int KEY_W      = 32;
  localparam int VAL_W      = 32;
  localparam int OCC_W      = 9;
  localparam int ENTRY_W    = KEY_W + VAL_W;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 48;

  typedef logic [1:0] op_t;
  localparam op_t CMD_GET    = 2'd0;
  localparam op_t CMD_PUT    = 2'd1;
  localparam op_t CMD_DELETE = 2'd2;

  typedef logic [1:0] res_t;
  localparam res_t ST_PRESENT = 2'd0;
  localparam res_t ST_ABSENT  = 2'd1;
  localparam res_t ST_FULL    = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic probe;
    logic compare;
    logic decide;
    logic shift_up;
    logic shift_down;
    logic write_entry;
    logic count_inc;
    logic count_dec;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic range_open;
    logic match;
    logic hit;
    logic is_put;
    logic is_delete;
    logic full;
    logic shift_done;
    logic out_free;
  } dp_status_t;

endpackage

// ===== sv/skvt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module skvt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/skvt_ctrl.sv =====
// Sequencer of the sorted key-value table: search, shift, write and result steps.
// Depends on skvt_pkg and the assertion macros in sorted_key_value_table_defines.svh.
`include "sorted_key_value_table_defines.svh"

module skvt_ctrl
  import skvt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  typedef enum logic [7:0] {
    S_IDLE       = 8'b0000_0001,
    S_PROBE      = 8'b0000_0010,
    S_COMPARE    = 8'b0000_0100,
    S_DECIDE     = 8'b0000_1000,
    S_SHIFT_UP   = 8'b0001_0000,
    S_SHIFT_DOWN = 8'b0010_0000,
    S_WRITE      = 8'b0100_0000,
    S_RESULT     = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (status.range_open) begin
          cmd.probe  = 1'b1;
          state_next = S_COMPARE;
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_COMPARE: begin
        cmd.compare = 1'b1;
        state_next  = status.match ? S_DECIDE : S_PROBE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (status.is_put) begin
          if (status.hit) begin
            state_next = S_WRITE;
          end else if (status.full) begin
            state_next = S_RESULT;
          end else begin
            state_next = S_SHIFT_UP;
          end
        end else if (status.is_delete && status.hit) begin
          state_next = S_SHIFT_DOWN;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_SHIFT_UP: begin
        cmd.shift_up = 1'b1;
        if (status.shift_done) begin
          state_next = S_WRITE;
        end
      end
      S_SHIFT_DOWN: begin
        cmd.shift_down = 1'b1;
        if (status.shift_done) begin
          cmd.count_dec = 1'b1;
          state_next    = S_RESULT;
        end
      end
      S_WRITE: begin
        cmd.write_entry = 1'b1;
        cmd.count_inc   = !status.hit;
        state_next      = S_RESULT;
      end
      S_RESULT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `SKVT_ASSERT_NOW(a_load_out_free, cmd.load_out, status.out_free, "result loaded over a pending transfer")
  `SKVT_ASSERT_NOW(a_shift_up_insert, state == S_SHIFT_UP, status.is_put && !status.hit && !status.full, "shift up outside an insert")
  `SKVT_ASSERT_NOW(a_shift_down_delete, state == S_SHIFT_DOWN, status.is_delete && status.hit, "shift down outside a delete")

endmodule

// ===== sv/skvt_datapath.sv =====
// Datapath of the sorted key-value table: search bounds, key compare, entry RAM,
// entry count and the output register. Depends on skvt_pkg, skvt_ram and the macros.
`include "sorted_key_value_table_defines.svh"

module skvt_datapath
  import skvt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  input  logic                  cfg_we,
  input  logic                  cfg_data,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic [1:0]            m_axis_tuser
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

  logic              signed_keys;
  op_t               op;
  logic [KEY_W-1:0]  key_r;
  logic [VAL_W-1:0]  val_r;
  logic [CNT_W-1:0]  count, lo, hi, mid, pos, ridx;
  logic [CNT_W:0]    mid_sum;
  logic [CNT_W-1:0]  pos_w;
  logic              hit;
  logic              rd_pend;
  logic [ADDR_W-1:0] last_addr;
  res_t              res_status;
  logic [VAL_W-1:0]  found;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [KEY_W-1:0]  sign_flip, ka, kb;
  logic              k_gt, k_lt;

  res_t              out_status;
  logic [VAL_W-1:0]  out_found;
  logic [OCC_W-1:0]  out_occ;

  // The probe index is floor((low + high) / 2) of the open interval (lo - 1, hi).
  assign mid_sum = {1'b0, lo} + {1'b0, hi} - 1'b1;

  // A miss ends with lo == hi; the insertion point is hi.
  assign pos_w = hit ? pos : hi;

  assign sign_flip = {signed_keys, {(KEY_W - 1){1'b0}}};
  assign ka   = key_r ^ sign_flip;
  assign kb   = ram_rdata[ENTRY_W-1 -: KEY_W] ^ sign_flip;
  assign k_gt = ka > kb;
  assign k_lt = ka < kb;

  // Only a put shifts up and only a delete shifts down, so the held command
  // selects which end condition applies.
  always_comb begin
    status            = '0;
    status.range_open = hi > lo;
    status.match      = !k_gt && !k_lt;
    status.hit        = hit;
    status.is_put     = (op == CMD_PUT);
    status.is_delete  = (op == CMD_DELETE);
    status.full       = (count == CNT_W'(TABLE_DEPTH));
    status.out_free   = !m_axis_tvalid || m_axis_tready;
    if (op == CMD_PUT) begin
      status.shift_done = !rd_pend && !(ridx > pos_w);
    end else begin
      status.shift_done = !rd_pend && !(ridx < count);
    end
  end

  // Entry RAM ports: shifts read one entry and write the one read in the previous cycle.
  always_comb begin
    ram_raddr = ADDR_W'(mid_sum[CNT_W:1]);
    if (cmd.shift_up) begin
      ram_raddr = ADDR_W'(ridx - 1'b1);
    end else if (cmd.shift_down) begin
      ram_raddr = ADDR_W'(ridx);
    end
    ram_we    = 1'b0;
    ram_waddr = last_addr;
    ram_wdata = ram_rdata;
    if (cmd.write_entry) begin
      ram_we    = 1'b1;
      ram_waddr = ADDR_W'(pos_w);
      ram_wdata = {key_r, val_r};
    end else if (cmd.shift_up && rd_pend) begin
      ram_we    = 1'b1;
      ram_waddr = last_addr + 1'b1;
    end else if (cmd.shift_down && rd_pend) begin
      ram_we    = 1'b1;
      ram_waddr = last_addr - 1'b1;
    end
  end

  skvt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_entries (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      signed_keys <= 1'b1;
    end else if (cfg_we) begin
      signed_keys <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.count_inc) begin
      count <= count + 1'b1;
    end else if (cmd.count_dec) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit     <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      if (cmd.load) begin
        hit <= 1'b0;
      end else if (cmd.compare && status.match) begin
        hit <= 1'b1;
      end
      if (cmd.decide) begin
        rd_pend <= 1'b0;
      end else if (cmd.shift_up) begin
        rd_pend <= ridx > pos_w;
      end else if (cmd.shift_down) begin
        rd_pend <= ridx < count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= s_axis_tuser;
      key_r <= s_axis_tdata[KEY_W-1:0];
      val_r <= s_axis_tdata[KEY_W +: VAL_W];
      lo    <= '0;
      hi    <= count;
      found <= '0;
    end
    if (cmd.probe) begin
      mid <= mid_sum[CNT_W:1];
    end
    if (cmd.compare) begin
      if (k_gt) begin
        lo <= mid + 1'b1;
      end else if (k_lt) begin
        hi <= mid;
      end else begin
        pos <= mid;
        if (op != CMD_PUT && op != CMD_DELETE) begin
          found <= ram_rdata[VAL_W-1:0];
        end
      end
    end
    if (cmd.decide) begin
      ridx <= (op == CMD_PUT) ? count : pos_w + 1'b1;
      if (hit) begin
        res_status <= ST_PRESENT;
      end else if (status.is_put && status.full) begin
        res_status <= ST_FULL;
      end else begin
        res_status <= ST_ABSENT;
      end
    end
    if (cmd.shift_up && ridx > pos_w) begin
      ridx      <= ridx - 1'b1;
      last_addr <= ADDR_W'(ridx - 1'b1);
    end
    if (cmd.shift_down && ridx < count) begin
      ridx      <= ridx + 1'b1;
      last_addr <= ADDR_W'(ridx);
    end
  end

  // Output register: a result waits here while the next item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status <= res_status;
      out_found  <= found;
      out_occ    <= OCC_W'(count);
    end
  end

  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {{(OUT_DATA_W - OCC_W - VAL_W){1'b0}}, out_occ, out_found};

  `SKVT_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(TABLE_DEPTH),
                   "entry count above table depth")
  `SKVT_ASSERT_NOW(a_insert_room, cmd.write_entry && !hit, count < CNT_W'(TABLE_DEPTH),
                   "insert into a full table")
  `SKVT_ASSERT_NOW(a_delete_nonempty, cmd.count_dec, count != '0 && hit,
                   "delete without a stored key")

endmodule

// ===== sv/sorted_key_value_table.sv =====
// Top level of the sorted key-value table: stream ports, controller and datapath.
// Depends on skvt_pkg, skvt_ctrl, skvt_datapath and skvt_ram.
//
// A map of up to TABLE_DEPTH 32-bit keys with 32-bit values, held in ascending key
// order in one RAM and searched by binary search. Each input transfer carries a get,
// put or delete (tuser, code 3 acts as a get) and yields exactly one result transfer
// with the status, the value found by a get and the occupancy after the operation.
// One item is processed at a time. Each search probe has a probe and a compare step and
// one RAM read (at most clog2(count+1) probes), and load, decision, write and result
// steps complete the item; an insert or delete also moves the entries past its
// position through the single RAM port pair. A result that has not been taken holds
// the next item in its final step until the output register frees.
// Writing signed_keys while entries are held does not reorder them.
module sorted_key_value_table
  import skvt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_data,      // signed_keys
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // key[31:0], new_value[63:32]
  input  logic [1:0]            s_axis_tuser,  // command[1:0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // found_value[31:0], occupancy[40:32]
  output logic [1:0]            m_axis_tuser   // status[1:0]
);

  dp_cmd_t    cmd;
  dp_status_t status;

  skvt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .cmd     (cmd),
    .status  (status)
  );

  skvt_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule

// ===== sim/tb_sorted_key_value_table.sv =====
// Self-checking testbench for the sorted key-value table: random and directed get, put
// and delete requests against a mirror of the sorted array that searches the same way.
// Depends on skvt_pkg and sorted_key_value_table.
`timescale 1ns / 100ps

module tb_sorted_key_value_table;
  import skvt_pkg::*;

  localparam int DEPTH = DEFAULT_TABLE_DEPTH;
  localparam int POOL_SIZE = 40;
  // The unused command code behaves as a get.
  localparam op_t CMD_UNUSED = 2'd3;

  typedef struct packed {
    op_t              cmd;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } request_t;

  typedef struct packed {
    res_t             status;
    logic [VAL_W-1:0] found;
    logic [OCC_W-1:0] occupancy;
  } reply_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic                  cfg_data = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // key[31:0], new_value[63:32]
  logic [1:0]            s_axis_tuser = '0;   // command[1:0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // found_value[31:0], occupancy[40:32]
  logic [1:0]            m_axis_tuser;        // status[1:0]

  sorted_key_value_table #(
    .TABLE_DEPTH(DEPTH)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #1 clk = ~clk;

  // Mirror of the table contents and of the key order register.
  logic [KEY_W-1:0] kv_keys [DEPTH];
  logic [VAL_W-1:0] kv_vals [DEPTH];
  int               kv_count = 0;
  bit               order_signed = 1'b1;

  request_t         request_queue [$];
  reply_t           expected_replies [$];
  request_t         request_on_bus;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int requests_queued = 0;
  int replies_seen = 0;
  int fail_count = 0;
  int full_refusals = 0;
  int peak_count = 0;

  function automatic int key_cmp(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
    logic [KEY_W-1:0] x;
    logic [KEY_W-1:0] y;
    // Flipping the sign bit turns a two's complement order into an unsigned one.
    x = a ^ {order_signed, {(KEY_W-1){1'b0}}};
    y = b ^ {order_signed, {(KEY_W-1){1'b0}}};
    if (x < y) return -1;
    if (x > y) return 1;
    return 0;
  endfunction

  // Binary search over the open interval (lo, hi), then the update of the table.
  function automatic reply_t table_apply(request_t req);
    reply_t rep;
    int     lo;
    int     hi;
    int     mid;
    int     pos;
    int     c;
    int     i;
    bit     hit;
    lo = -1;
    hi = kv_count;
    pos = 0;
    hit = 1'b0;
    rep.status = ST_ABSENT;
    rep.found = '0;
    while (!hit && hi - lo > 1) begin
      mid = lo + (hi - lo) / 2;
      c = key_cmp(req.key, kv_keys[mid]);
      if (c > 0) begin
        lo = mid;
      end else if (c < 0) begin
        hi = mid;
      end else begin
        hit = 1'b1;
        pos = mid;
      end
    end
    if (!hit) pos = hi;
    case (req.cmd)
      CMD_PUT: begin
        if (hit) begin
          kv_vals[pos] = req.value;
          rep.status = ST_PRESENT;
        end else if (kv_count >= DEPTH) begin
          rep.status = ST_FULL;
          full_refusals++;
        end else begin
          for (i = kv_count; i > pos; i--) begin
            kv_keys[i] = kv_keys[i-1];
            kv_vals[i] = kv_vals[i-1];
          end
          kv_keys[pos] = req.key;
          kv_vals[pos] = req.value;
          kv_count++;
        end
      end
      CMD_DELETE: begin
        if (hit) begin
          for (i = pos; i + 1 < kv_count; i++) begin
            kv_keys[i] = kv_keys[i+1];
            kv_vals[i] = kv_vals[i+1];
          end
          kv_count--;
          rep.status = ST_PRESENT;
        end
      end
      default: begin
        if (hit) begin
          rep.found = kv_vals[pos];
          rep.status = ST_PRESENT;
        end
      end
    endcase
    if (kv_count > peak_count) peak_count = kv_count;
    rep.occupancy = OCC_W'(kv_count);
    return rep;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR result %0d: %s is %0h, expected %0h", replies_seen, what, got, want);
    fail_count++;
  endtask

  // Driver: the next queued request follows each taken one unless the sender idles.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_replies.push_back(table_apply(request_on_bus));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (request_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          request_on_bus = request_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {request_on_bus.value, request_on_bus.key};
          s_axis_tuser <= request_on_bus.cmd;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("unexpected result, tdata", m_axis_tdata, '0);
        end else begin
          want = expected_replies.pop_front();
          if (m_axis_tuser !== want.status)
            report_mismatch("status", m_axis_tuser, want.status);
          if (m_axis_tdata[VAL_W-1:0] !== want.found)
            report_mismatch("found_value", m_axis_tdata[VAL_W-1:0], want.found);
          if (m_axis_tdata[VAL_W +: OCC_W] !== want.occupancy)
            report_mismatch("occupancy", m_axis_tdata[VAL_W +: OCC_W], want.occupancy);
        end
        replies_seen++;
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic queue_request(op_t cmd, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
    request_queue.push_back('{cmd: cmd, key: key, value: value});
    requests_queued++;
  endtask

  // Every request yields one result, so the table is idle once all results are in.
  task automatic wait_drained();
    while (replies_seen != requests_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_key_order(bit is_signed);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= is_signed;
    @(posedge clk);
    cfg_we <= 1'b0;
    order_signed = is_signed;
  endtask

  task automatic set_idling(int sender_pct, int stall_pct);
    sender_idle_pct = sender_pct;
    recv_stall_pct = stall_pct;
  endtask

  // Most keys come from a small pool so that puts, gets and deletes meet each other.
  task automatic queue_random(int n);
    int               r;
    op_t              cmd;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 40) cmd = CMD_PUT;
      else if (r < 70) cmd = CMD_GET;
      else if (r < 96) cmd = CMD_DELETE;
      else cmd = CMD_UNUSED;
      key = ($urandom_range(99) < 75) ? key_pool[$urandom_range(POOL_SIZE-1)] : $urandom;
      case ($urandom_range(15))
        0: value = 32'h8000_0000;
        1: value = 32'h7FFF_FFFF;
        2: value = 32'hFFFF_FFFF;
        default: value = $urandom;
      endcase
      queue_request(cmd, key, value);
    end
  endtask

  // Deleting from the highest position down keeps every removal free of shifts.
  task automatic queue_clear_table();
    int i;
    for (i = kv_count - 1; i >= 0; i--) queue_request(CMD_DELETE, kv_keys[i], $urandom);
  endtask

  initial begin
    int               i;
    logic [KEY_W-1:0] fill_base;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'h0000_0001;
    key_pool[2] = 32'h7FFF_FFFF;
    key_pool[3] = 32'h8000_0000;
    key_pool[4] = 32'hFFFF_FFFF;
    key_pool[5] = 32'h8000_0001;
    key_pool[6] = 32'hFFFF_FFFE;
    key_pool[7] = 32'h7FFF_FFFE;
    for (i = 8; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed requests with two's complement ordering.
    set_idling(0, 0);
    set_key_order(1'b1);
    queue_request(CMD_GET, 32'h0000_0000, 32'h0);
    queue_request(CMD_DELETE, 32'h0000_0000, 32'h0);
    queue_request(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_request(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_request(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
    queue_request(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(CMD_PUT, 32'h0000_0001, 32'h0000_0001);
    queue_request(CMD_GET, 32'h8000_0000, 32'h0);
    queue_request(CMD_GET, 32'h7FFF_FFFF, 32'h0);
    queue_request(CMD_GET, 32'hFFFF_FFFF, 32'h0);
    queue_request(CMD_PUT, 32'h0000_0000, 32'h5A5A_A5A5);
    queue_request(CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_request(CMD_UNUSED, 32'h0000_0000, 32'h1234_5678);
    queue_request(CMD_UNUSED, 32'h0000_0002, 32'h1234_5678);
    queue_request(CMD_GET, 32'h0000_0002, 32'h0);
    queue_request(CMD_DELETE, 32'hFFFF_FFFF, 32'h0);
    queue_request(CMD_DELETE, 32'h0000_0002, 32'h0);
    queue_request(CMD_DELETE, 32'h7FFF_FFFF, 32'h0);
    queue_request(CMD_GET, 32'hFFFF_FFFF, 32'h0);
    queue_request(CMD_GET, 32'h8000_0000, 32'h0);
    wait_drained();

    queue_random(120);
    wait_drained();
    set_idling(80, 0);
    queue_random(120);
    wait_drained();
    queue_clear_table();
    wait_drained();

    set_key_order(1'b0);
    set_idling(0, 80);
    queue_random(120);
    wait_drained();
    queue_clear_table();
    wait_drained();

    // Fill the table with ascending keys, then work at and around the full limit.
    set_idling(35, 35);
    fill_base = 32'hA000_0000;
    for (i = 0; i < DEPTH; i++) queue_request(CMD_PUT, fill_base + (i << 8), $urandom);
    queue_request(CMD_PUT, fill_base + (DEPTH << 8), $urandom);
    queue_request(CMD_PUT, 32'h0000_0000, $urandom);
    queue_request(CMD_PUT, 32'hFFFF_FFFF, $urandom);
    queue_request(CMD_PUT, fill_base + ((DEPTH - 1) << 8), 32'h1234_5678);
    queue_request(CMD_GET, fill_base + ((DEPTH - 1) << 8), 32'h0);
    queue_request(CMD_GET, 32'h0000_0000, 32'h0);
    queue_request(CMD_DELETE, fill_base, 32'h0);
    queue_request(CMD_PUT, 32'h0000_0000, 32'hCAFE_0001);
    queue_request(CMD_PUT, 32'h0000_0001, $urandom);
    queue_request(CMD_DELETE, fill_base + (128 << 8), 32'h0);
    queue_request(CMD_GET, fill_base + (200 << 8), 32'h0);
    queue_request(CMD_GET, 32'h0000_0000, 32'h0);
    wait_drained();
    queue_clear_table();
    wait_drained();

    set_key_order(1'b1);
    queue_random(120);
    wait_drained();

    // The order changes while entries are held; the stored order stays as it is.
    set_key_order(1'b0);
    set_idling(0, 0);
    queue_random(100);
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Checked %0d results for %0d requests; peak occupancy %0d, %0d puts refused full.",
             replies_seen, requests_queued, peak_count, full_refusals);
    $display("Both key orders were used, one switch of order with entries still held.");
    if (fail_count == 0) begin
      $display("tb_sorted_key_value_table OK");
    end else begin
      $display("tb_sorted_key_value_table NOT OK");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timeout with %0d of %0d results received.", replies_seen, requests_queued);
    $display("tb_sorted_key_value_table NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/skvt_pkg.sv
sv/skvt_ram.sv
sv/skvt_ctrl.sv
sv/skvt_datapath.sv
sv/sorted_key_value_table.sv
sim/tb_sorted_key_value_table.sv
